### rtl/core/hlbu_pkg.sv
// Shared types, constants and Q16.16 arithmetic helpers of the hidden-layer backprop engine.
`timescale 1ns / 1ps
package hlbu_pkg;

    localparam logic [2:0] OP_ACC = 3'd0;
    localparam logic [2:0] OP_FIN = 3'd1;
    localparam logic [2:0] OP_UPD = 3'd2;
    localparam logic [2:0] OP_RD  = 3'd3;
    localparam logic [2:0] OP_WR  = 3'd4;

    localparam logic [16:0] LR_RESET = 17'd655;
    localparam logic signed [32:0] Q_ONE = 33'sd65536;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         unit_index;
        logic [8:0]         input_index;
        logic signed [31:0] value;
        logic signed [31:0] next_delta;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [5:0]         result_unit;
        logic               is_delta;
        logic               saturated;
    } t_out_rsp;

    typedef struct packed {
        logic shift;
        logic delta_we;
        logic sum_we;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
    } t_qres;

    // Product of two Q16.16 values, floored back to Q16.16 and saturated.
    function automatic t_qres qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [47:0] q;
        t_qres r;
        p = 64'(a) * 64'(b);
        q = p[63:16];
        r.sat = 1'b0;
        r.value = q[31:0];
        if (!q[47] && (|q[46:31])) begin
            r.sat = 1'b1;
            r.value = 32'sh7FFFFFFF;
        end else if (q[47] && !(&q[46:31])) begin
            r.sat = 1'b1;
            r.value = 32'sh80000000;
        end
        return r;
    endfunction

    // Saturating clamp of a 33-bit signed value to 32 bits.
    function automatic t_qres clamp33(input logic signed [32:0] s);
        t_qres r;
        r.sat = (s[32] != s[31]);
        if (!r.sat) begin
            r.value = s[31:0];
        end else if (s[32]) begin
            r.value = 32'sh80000000;
        end else begin
            r.value = 32'sh7FFFFFFF;
        end
        return r;
    endfunction

    function automatic t_qres qadd(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return clamp33(s);
    endfunction

endpackage

### rtl/core/hlbu_cell.sv
// One hidden-unit cell: holds the unit's delta and error sum; deltas rotate along the row.
`timescale 1ns / 1ps
module hlbu_cell
    import hlbu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_delta_in,
    input  logic signed [31:0] i_delta_wdata,
    input  logic signed [31:0] i_sum_wdata,
    output logic signed [31:0] o_delta,
    output logic signed [31:0] o_sum
);

    logic signed [31:0] r_delta;
    logic signed [31:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
            r_sum   <= '0;
        end else begin
            if (i_ctl.shift) begin
                r_delta <= i_delta_in;
            end else if (i_ctl.delta_we) begin
                r_delta <= i_delta_wdata;
            end
            if (i_ctl.sum_we) begin
                r_sum <= i_sum_wdata;
            end
        end
    end

    assign o_delta = r_delta;
    assign o_sum   = r_sum;

endmodule

### rtl/core/hidden_layer_backprop_update.sv
// Top level of the hidden-layer backpropagation engine with weight and bias stores.
`timescale 1ns / 1ps
// Usage. Requests arrive on i_in (valid/ready) and carry one operation each: accumulate an
// error term, finish a unit, update one input column in every unit, read or write a weight.
// Finish and read requests answer with one result on o_out (valid/ready); the others answer
// nothing. The learning rate is written through the i_cfg channel, which is always ready and
// must only be used while the engine is idle.
// Timing. One request is worked on at a time and o_in_ready is high only when idle. A column
// update walks the row of OUT_UNITS cells through one memory read port and one write port,
// one unit per cycle; this walk sets the sustained rate.
// Reset clears the deltas, the error sums and the output valid flag and loads the default
// learning rate; weights and biases hold nothing defined until they are written.
// Stalls. A finished result sits in the output register while the next request is taken;
// a second result waits in its last step until the receiver has taken the first.
module hidden_layer_backprop_update
    import hlbu_pkg::*;
#(
    parameter int OUT_UNITS = 64,
    parameter int IN_WIDTH  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_rsp    o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    localparam int UW    = (OUT_UNITS > 1) ? $clog2(OUT_UNITS) : 1;
    localparam int DEPTH = OUT_UNITS * IN_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(OUT_UNITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ACC1, S_ACC2, S_FIN1, S_FIN2, S_FIN3, S_FIN4,
        S_UPD, S_DRAIN, S_RD, S_RD2, S_WR, S_EMIT
    } t_state;

    t_state             r_state;
    t_in_req            r_req;
    logic [UW-1:0]      r_unit_sel;
    logic               r_col_lt;
    logic               r_col_eq;
    logic               r_unit_ok;
    logic [16:0]        r_lr;
    logic [AW-1:0]      r_waddr;
    logic [CNTW-1:0]    r_cnt;
    logic signed [31:0] r_t;
    logic signed [31:0] r_om;
    logic signed [31:0] r_d;
    logic signed [31:0] r_step;
    logic signed [31:0] r_prod;
    logic signed [31:0] r_res;
    logic               r_sat;
    logic               r_out_valid;
    t_out_rsp           r_out;

    // Column update pipeline: stage one holds the gain, stage two the weight step.
    logic               r_v1;
    logic               r_v2;
    logic [AW-1:0]      r_a1;
    logic [AW-1:0]      r_a2;
    logic signed [31:0] r_g;
    logic signed [31:0] r_ustep;
    logic signed [31:0] r_rd2;

    logic signed [31:0] r_wrdata;
    logic signed [31:0] r_bias_rd;
    logic signed [31:0] weights [DEPTH];
    logic signed [31:0] biases [OUT_UNITS];

    logic signed [31:0] w_delta [OUT_UNITS];
    logic signed [31:0] w_sum [OUT_UNITS];
    t_cell_ctl          w_ctl [OUT_UNITS];
    logic signed [31:0] w_sum_sel;
    logic signed [31:0] w_sum_wdata;
    t_qres              w_acc;
    t_qres              w_bias_new;
    t_qres              w_wnew;
    logic signed [31:0] w_lr_s;

    logic [31:0] w_unit32;
    logic [31:0] w_col32;
    logic        w_unit_ok;
    logic        w_col_lt;
    logic        w_col_eq;
    logic [31:0] w_addr32;
    logic        w_accept;

    logic              w_wr_we;
    logic [AW-1:0]     w_wr_addr;
    logic signed [31:0] w_wr_data;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_unit32  = 32'(i_in.unit_index);
    assign w_col32   = 32'(i_in.input_index);
    assign w_unit_ok = w_unit32 < 32'(OUT_UNITS);
    assign w_col_lt  = w_col32 < 32'(IN_WIDTH);
    assign w_col_eq  = w_col32 == 32'(IN_WIDTH);
    assign w_addr32  = (w_unit_ok && w_col_lt) ? (w_unit32 * 32'(IN_WIDTH) + w_col32) : '0;
    assign w_lr_s    = $signed({15'b0, r_lr});

    // The row of cells; delta leaves cell zero and every cell takes its right neighbour's.
    genvar gi;
    generate
        for (gi = 0; gi < OUT_UNITS; gi++) begin : g_cell
            always_comb begin
                w_ctl[gi].shift    = (r_state == S_UPD) && (r_cnt < CNTW'(OUT_UNITS));
                w_ctl[gi].delta_we = (r_state == S_FIN3) && (r_unit_sel == UW'(gi));
                w_ctl[gi].sum_we   = ((r_state == S_ACC2) || (r_state == S_FIN3))
                                     && (r_unit_sel == UW'(gi));
            end
            hlbu_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[gi]),
                .i_delta_in   (w_delta[(gi + 1) % OUT_UNITS]),
                .i_delta_wdata(r_d),
                .i_sum_wdata  (w_sum_wdata),
                .o_delta      (w_delta[gi]),
                .o_sum        (w_sum[gi])
            );
        end
    endgenerate

    assign w_sum_sel   = w_sum[r_unit_sel];
    assign w_acc       = qadd(w_sum_sel, r_prod);
    assign w_sum_wdata = (r_state == S_FIN3) ? 32'sd0 : w_acc.value;
    assign w_bias_new  = qadd(r_bias_rd, r_step);
    assign w_wnew      = qadd(r_rd2, r_ustep);

    assign w_wr_we   = ((r_state == S_WR) && r_col_lt) || r_v2;
    assign w_wr_addr = r_v2 ? r_a2 : r_waddr;
    assign w_wr_data = r_v2 ? w_wnew.value : r_req.value;

    always_ff @(posedge i_clk) begin
        if (w_wr_we) begin
            weights[w_wr_addr] <= w_wr_data;
        end
        r_wrdata <= weights[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN4) begin
            biases[r_unit_sel] <= w_bias_new.value;
        end else if ((r_state == S_WR) && r_col_eq) begin
            biases[r_unit_sel] <= r_req.value;
        end
        r_bias_rd <= biases[r_unit_sel];
    end

    always_ff @(posedge i_clk) begin
        t_qres q1;
        t_qres q2;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lr        <= LR_RESET;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_lr <= i_cfg_data;
            end
            // The emit step reloads the output register itself.
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            // Column update pipeline stages one and two.
            r_v2    <= r_v1;
            r_a2    <= r_a1;
            r_rd2   <= r_wrdata;
            q2      = qmul(r_g, r_req.value);
            r_ustep <= q2.value;
            r_v1    <= (r_state == S_UPD) && (r_cnt < CNTW'(OUT_UNITS));

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req      <= i_in;
                        r_unit_sel <= w_unit32[UW-1:0];
                        r_unit_ok  <= w_unit_ok;
                        r_col_lt   <= w_col_lt;
                        r_col_eq   <= w_col_eq;
                        r_sat      <= 1'b0;
                        r_cnt      <= '0;
                        r_waddr    <= (i_in.operation == OP_UPD) ? w_col32[AW-1:0]
                                                                 : w_addr32[AW-1:0];
                        case (i_in.operation)
                            OP_ACC: r_state <= w_unit_ok ? S_ACC1 : S_IDLE;
                            OP_FIN: r_state <= w_unit_ok ? S_FIN1 : S_IDLE;
                            OP_UPD: r_state <= w_col_lt ? S_UPD : S_IDLE;
                            OP_RD:  r_state <= S_RD;
                            OP_WR:  r_state <= (w_unit_ok && (w_col_lt || w_col_eq))
                                               ? S_WR : S_IDLE;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ACC1: begin
                    q1 = qmul(r_req.value, r_req.next_delta);
                    r_prod  <= q1.value;
                    r_state <= S_ACC2;
                end
                S_ACC2: begin
                    r_state <= S_IDLE;
                end
                S_FIN1: begin
                    q1 = qmul(w_sum_sel, r_req.value);
                    q2 = clamp33(Q_ONE - 33'(r_req.value));
                    r_t     <= q1.value;
                    r_om    <= q2.value;
                    r_sat   <= q1.sat || q2.sat;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    q1 = qmul(r_t, r_om);
                    r_d     <= q1.value;
                    r_sat   <= r_sat || q1.sat;
                    r_state <= S_FIN3;
                end
                S_FIN3: begin
                    q1 = qmul(w_lr_s, r_d);
                    r_step  <= q1.value;
                    r_sat   <= r_sat || q1.sat;
                    r_state <= S_FIN4;
                end
                S_FIN4: begin
                    r_res   <= r_d;
                    r_sat   <= r_sat || w_bias_new.sat;
                    r_state <= S_EMIT;
                end
                S_UPD: begin
                    if (r_cnt < CNTW'(OUT_UNITS)) begin
                        q1 = qmul(w_lr_s, w_delta[0]);
                        r_g     <= q1.value;
                        r_a1    <= r_waddr;
                        r_waddr <= r_waddr + AW'(IN_WIDTH);
                        r_cnt   <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    if (!r_unit_ok) begin
                        r_res <= '0;
                    end else if (r_col_lt) begin
                        r_res <= r_wrdata;
                    end else if (r_col_eq) begin
                        r_res <= r_bias_rd;
                    end else begin
                        r_res <= '0;
                    end
                    r_state <= S_EMIT;
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid        <= 1'b1;
                        r_out.result_value <= r_res;
                        r_out.result_unit  <= r_req.unit_index;
                        r_out.is_delta     <= (r_req.operation == OP_FIN);
                        r_out.saturated    <= (r_req.operation == OP_FIN) && r_sat;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // The update pipeline is empty whenever a new request may enter.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_v1 && !r_v2))
        else $error("update pipeline busy while idle");

    // A weight write-back always follows a read stage in the cycle before.
    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("write-back without a preceding read stage");

    // The walk never issues more units than the row holds.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_cnt <= CNTW'(OUT_UNITS)) && (r_cnt != '0))
        else $error("column walk out of range");

endmodule
